[rtl/similar_triangle_match_assert.svh]
// assertion macros for the similar triangle match checker
// expects clk and rst_n in the scope of use
`ifndef SIMILAR_TRIANGLE_MATCH_ASSERT_SVH
`define SIMILAR_TRIANGLE_MATCH_ASSERT_SVH
// condition holds at every edge out of reset
`define STM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("stm assertion failed");
// implication between two properties
`define STM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("stm assertion failed");
`endif

[rtl/stm_pkg.sv]
// shared constants, types and the vertex pairing table for similar_triangle_match
// no dependencies
package stm_pkg;
  localparam int STM_IN_AW = 15;
  localparam int STM_AW    = 16;
  localparam int STM_SW    = 24;
  localparam int STM_RF    = 8;
  localparam int STM_QW    = STM_SW + STM_RF;
  localparam int STM_LAT   = STM_QW + 2;
  localparam int STM_NP    = 6;
  localparam int STM_CW    = 16;
  localparam int STM_RW    = 12;
  localparam int STM_LW    = STM_RW + 2;

  typedef enum logic [1:0] {
    REG_THR = 2'd0,
    REG_MAX = 2'd1,
    REG_MIN = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [2*STM_CW-1:0] thr_sq;
    logic [STM_LW-1:0]   hi_lim;
    logic [STM_LW-1:0]   lo_lim;
  } limits_t;

  // second vertex matched to first vertex v under correspondence p
  localparam logic [1:0] PAIR [STM_NP][3] = '{
    '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd2},
    '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd0, 2'd1}
  };
endpackage

[rtl/similar_triangle_match.sv]
// similar_triangle_match top level: nine divider and squarer lanes plus merge
// depends on stm_pkg, stm_div, stm_merge
// One item (a pair of triangles) may be started every cycle; busy never rises.
// The mask is driven on out_match_mask with out_valid after the 32-stage pipelined
// side-ratio dividers (the first stage loads at the accepting edge) and the two merge
// stages. Results come once, for one cycle, in accept order.
// Configuration writes take effect once they pass the config registers and lim_r.
module similar_triangle_match import stm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [STM_IN_AW-1:0] in_first_angle_a,
  input  logic [STM_IN_AW-1:0] in_first_angle_b,
  input  logic [STM_IN_AW-1:0] in_first_angle_c,
  input  logic [STM_SW-1:0]    in_first_side_a,
  input  logic [STM_SW-1:0]    in_first_side_b,
  input  logic [STM_SW-1:0]    in_first_side_c,
  input  logic [STM_IN_AW-1:0] in_second_angle_a,
  input  logic [STM_IN_AW-1:0] in_second_angle_b,
  input  logic [STM_IN_AW-1:0] in_second_angle_c,
  input  logic [STM_SW-1:0]    in_second_side_a,
  input  logic [STM_SW-1:0]    in_second_side_b,
  input  logic [STM_SW-1:0]    in_second_side_c,
  output logic                 out_valid,
  output logic [STM_NP-1:0]    out_match_mask,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [STM_CW-1:0]    cfg_wdata
);
  logic [STM_CW-1:0] thr_r;
  logic [STM_RW-1:0] max_r;
  logic [STM_RW-1:0] min_r;
  limits_t           lim_r;

  logic [STM_AW-1:0] a1 [3];
  logic [STM_AW-1:0] a2 [3];
  logic [STM_SW-1:0] s1 [3];
  logic [STM_SW-1:0] s2 [3];

  logic [2*STM_AW-1:0] sq_nxt [9];
  logic [2*STM_AW-1:0] sq_r   [STM_QW][9];
  logic [2:0]          zero_r [STM_QW];
  logic [STM_QW-1:0]   vld_r;
  logic [STM_QW-1:0]   quo [9];
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign a1 = '{{1'b0, in_first_angle_a}, {1'b0, in_first_angle_b}, {1'b0, in_first_angle_c}};
  assign a2 = '{{1'b0, in_second_angle_a}, {1'b0, in_second_angle_b},
                {1'b0, in_second_angle_c}};
  assign s1 = '{in_first_side_a, in_first_side_b, in_first_side_c};
  assign s2 = '{in_second_side_a, in_second_side_b, in_second_side_c};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= STM_CW'(410);
      max_r <= STM_RW'(640);
      min_r <= STM_RW'(102);
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_THR: thr_r <= cfg_wdata;
        REG_MAX: max_r <= cfg_wdata[STM_RW-1:0];
        REG_MIN: min_r <= cfg_wdata[STM_RW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim_r.thr_sq <= thr_r * thr_r;
    lim_r.hi_lim <= {1'b0, max_r, 1'b0} + {2'b00, max_r} + STM_LW'(2);
    lim_r.lo_lim <= {1'b0, min_r, 1'b0} + {2'b00, min_r};
  end

  // lane index v*3+w pairs first vertex v with second vertex w
  for (genvar v = 0; v < 3; v++) begin : g_v
    for (genvar w = 0; w < 3; w++) begin : g_w
      logic [STM_AW-1:0] d;
      assign d = (a1[v] >= a2[w]) ? (a1[v] - a2[w]) : (a2[w] - a1[v]);
      assign sq_nxt[v*3+w] = d * d;
      stm_div u_div (
        .clk     (clk),
        .in_dvd  ({s2[w], {STM_RF{1'b0}}}),
        .in_dsr  (s1[v]),
        .out_quo (quo[v*3+w])
      );
    end
  end

  always_ff @(posedge clk) begin
    sq_r[0]   <= sq_nxt;
    zero_r[0] <= {s1[2] == '0, s1[1] == '0, s1[0] == '0};
    for (int k = 1; k < STM_QW; k++) begin
      sq_r[k]   <= sq_r[k-1];
      zero_r[k] <= zero_r[k-1];
    end
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STM_QW-2:0], accept};
    end
  end

  stm_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_r[STM_QW-1]),
    .in_sq    (sq_r[STM_QW-1]),
    .in_quo   (quo),
    .in_zero  (zero_r[STM_QW-1]),
    .lim      (lim_r),
    .out_vld  (out_valid),
    .out_mask (out_match_mask)
  );
endmodule

[rtl/stm_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on stm_pkg
module stm_div import stm_pkg::*; (
  input  logic              clk,
  input  logic [STM_QW-1:0] in_dvd,
  input  logic [STM_SW-1:0] in_dsr,
  output logic [STM_QW-1:0] out_quo
);
  // upper part remainder, lower part dividend bits shifting into quotient
  logic [STM_SW+STM_QW-1:0] acc_r [STM_QW];
  logic [STM_SW-1:0]        dsr_r [STM_QW];

  for (genvar k = 0; k < STM_QW; k++) begin : g_stage
    logic [STM_SW+STM_QW-1:0] src;
    logic [STM_SW-1:0]        dsrc;
    logic [STM_SW+STM_QW:0]   sh;
    logic [STM_SW:0]          up;
    logic [STM_SW:0]          up_sub;
    logic                     qb;
    logic [STM_SW+STM_QW-1:0] acc_nxt;
    if (k == 0) begin : g_first
      assign src  = {{STM_SW{1'b0}}, in_dvd};
      assign dsrc = in_dsr;
    end else begin : g_rest
      assign src  = acc_r[k-1];
      assign dsrc = dsr_r[k-1];
    end
    always_comb begin
      sh      = {src, 1'b0};
      up      = sh[STM_SW+STM_QW:STM_QW];
      qb      = (up >= {1'b0, dsrc});
      up_sub  = qb ? (up - {1'b0, dsrc}) : up;
      acc_nxt = {up_sub[STM_SW-1:0], sh[STM_QW-1:1], qb};
    end
    always_ff @(posedge clk) begin
      acc_r[k] <= acc_nxt;
      dsr_r[k] <= dsrc;
    end
  end

  assign out_quo = acc_r[STM_QW-1][STM_QW-1:0];
endmodule

[rtl/stm_merge.sv]
// merging stage: combines lane squares and ratios into the correspondence mask
// depends on stm_pkg
module stm_merge import stm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [2*STM_AW-1:0] in_sq [9],
  input  logic [STM_QW-1:0]   in_quo [9],
  input  logic [2:0]          in_zero,
  input  limits_t             lim,
  output logic                out_vld,
  output logic [STM_NP-1:0]   out_mask
);
  logic [2*STM_AW+1:0] dist_r [STM_NP];
  logic [STM_QW+1:0]   rsum_r [STM_NP];
  logic                bad_r;
  logic                vld_r;
  logic [STM_NP-1:0]   mask_nxt;

  always_ff @(posedge clk) begin
    for (int p = 0; p < STM_NP; p++) begin
      dist_r[p] <= {2'b00, in_sq[4'(PAIR[p][0])]}
                 + {2'b00, in_sq[4'd3 + 4'(PAIR[p][1])]}
                 + {2'b00, in_sq[4'd6 + 4'(PAIR[p][2])]};
      rsum_r[p] <= {2'b00, in_quo[4'(PAIR[p][0])]}
                 + {2'b00, in_quo[4'd3 + 4'(PAIR[p][1])]}
                 + {2'b00, in_quo[4'd6 + 4'(PAIR[p][2])]};
    end
    bad_r <= |in_zero;
  end

  // floor(sum/3) in [min,max] is 3*min <= sum <= 3*max+2
  always_comb begin
    for (int p = 0; p < STM_NP; p++) begin
      mask_nxt[p] = !bad_r
        && (dist_r[p] <= {2'b00, lim.thr_sq})
        && (rsum_r[p] <= {{(STM_QW+2-STM_LW){1'b0}}, lim.hi_lim})
        && (rsum_r[p] >= {{(STM_QW+2-STM_LW){1'b0}}, lim.lo_lim});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld_r   <= in_vld;
      out_vld <= vld_r;
    end
    out_mask <= mask_nxt;
  end
endmodule

[rtl/stm_checker.sv]
// port-level checker for similar_triangle_match, bound to the top level
// depends on stm_pkg and similar_triangle_match_assert.svh
`include "similar_triangle_match_assert.svh"
module stm_checker import stm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [STM_NP-1:0] out_match_mask
);
  `STM_ASSERT_ALWAYS(a_never_busy, !busy)
  `STM_ASSERT_IMPL(a_item_gives_result, start && !busy, ##STM_LAT out_valid)
  `STM_ASSERT_IMPL(a_result_has_item, out_valid, $past(start && !busy, STM_LAT))
  `STM_ASSERT_IMPL(a_mask_known, out_valid, !$isunknown(out_match_mask))
endmodule

bind similar_triangle_match stm_checker u_stm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_match_mask (out_match_mask)
);
